// ===== rtl/core/assert_macros.svh =====
// assertion helpers, sampled on clk and off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SSAS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssas assertion failed");

// next-cycle implication
`define SSAS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssas assertion failed");

`endif

// ===== rtl/core/ssas_pkg.sv =====
package ssas_pkg;

    localparam int unsigned SAMPLE_W = 32;
    localparam int unsigned FMT_W    = 3;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 3;

    localparam logic [FMT_W-1:0] FMT_U8  = 3'd0;
    localparam logic [FMT_W-1:0] FMT_S8  = 3'd1;
    localparam logic [FMT_W-1:0] FMT_O8  = 3'd2;
    localparam logic [FMT_W-1:0] FMT_U16 = 3'd3;
    localparam logic [FMT_W-1:0] FMT_S16 = 3'd4;
    localparam logic [FMT_W-1:0] FMT_O16 = 3'd5;
    localparam logic [FMT_W-1:0] FMT_S32 = 3'd6;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_SUB = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OPERATION = 1'b1;

    typedef struct packed {
        logic [FMT_W-1:0] sample_format;
        logic             operation;
    } ssas_cfg_t;

endpackage

// ===== rtl/core/ssas_cfg.sv =====
module ssas_cfg
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ssas_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ssas_pkg::CFG_DATA_W-1:0]      cfg_data,
    output ssas_pkg::ssas_cfg_t                  cfg
);

    ssas_pkg::ssas_cfg_t cfg_reg;
    ssas_pkg::ssas_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                ssas_pkg::CFG_FORMAT:
                begin
                    cfg_next.sample_format = cfg_data[ssas_pkg::FMT_W-1:0];
                end
                ssas_pkg::CFG_OPERATION:
                begin
                    cfg_next.operation = cfg_data[0];
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sample_format <= ssas_pkg::FMT_U8;
            cfg_reg.operation     <= ssas_pkg::OP_ADD;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/core/ssas_alu.sv =====
module ssas_alu
(
    input  ssas_pkg::ssas_cfg_t                  cfg,
    input  logic [ssas_pkg::SAMPLE_W-1:0]        first_sample,
    input  logic [ssas_pkg::SAMPLE_W-1:0]        second_sample,
    output logic [ssas_pkg::SAMPLE_W-1:0]        result_sample
);

    localparam logic [1:0] W8  = 2'd0;
    localparam logic [1:0] W16 = 2'd1;
    localparam logic [1:0] W32 = 2'd2;

    logic signed [33:0] a_s;
    logic signed [33:0] b_s;
    logic signed [33:0] lo_s;
    logic signed [33:0] hi_s;
    logic signed [33:0] sum_s;
    logic signed [33:0] clip_s;
    logic [1:0]         wcls;
    logic               off_flag;
    logic               fmt_ok;

    // operands widened to 34 bits, offset formats centered by flipping the msb
    always_comb
    begin
        a_s      = '0;
        b_s      = '0;
        lo_s     = '0;
        hi_s     = '0;
        wcls     = W8;
        off_flag = 1'b0;
        fmt_ok   = 1'b1;
        case (cfg.sample_format)
            ssas_pkg::FMT_U8:
            begin
                a_s  = {26'b0, first_sample[7:0]};
                b_s  = {26'b0, second_sample[7:0]};
                hi_s = 34'sd255;
            end
            ssas_pkg::FMT_S8:
            begin
                a_s  = {{26{first_sample[7]}}, first_sample[7:0]};
                b_s  = {{26{second_sample[7]}}, second_sample[7:0]};
                lo_s = -34'sd128;
                hi_s = 34'sd127;
            end
            ssas_pkg::FMT_O8:
            begin
                a_s      = {{27{~first_sample[7]}}, first_sample[6:0]};
                b_s      = {{27{~second_sample[7]}}, second_sample[6:0]};
                lo_s     = -34'sd128;
                hi_s     = 34'sd127;
                off_flag = 1'b1;
            end
            ssas_pkg::FMT_U16:
            begin
                a_s  = {18'b0, first_sample[15:0]};
                b_s  = {18'b0, second_sample[15:0]};
                hi_s = 34'sd65535;
                wcls = W16;
            end
            ssas_pkg::FMT_S16:
            begin
                a_s  = {{18{first_sample[15]}}, first_sample[15:0]};
                b_s  = {{18{second_sample[15]}}, second_sample[15:0]};
                lo_s = -34'sd32768;
                hi_s = 34'sd32767;
                wcls = W16;
            end
            ssas_pkg::FMT_O16:
            begin
                a_s      = {{19{~first_sample[15]}}, first_sample[14:0]};
                b_s      = {{19{~second_sample[15]}}, second_sample[14:0]};
                lo_s     = -34'sd32768;
                hi_s     = 34'sd32767;
                wcls     = W16;
                off_flag = 1'b1;
            end
            ssas_pkg::FMT_S32:
            begin
                a_s  = {{2{first_sample[31]}}, first_sample};
                b_s  = {{2{second_sample[31]}}, second_sample};
                lo_s = -34'sd2147483648;
                hi_s = 34'sd2147483647;
                wcls = W32;
            end
            default:
            begin
                fmt_ok = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        sum_s = (cfg.operation == ssas_pkg::OP_SUB) ? (a_s - b_s) : (a_s + b_s);
        if (sum_s > hi_s)
        begin
            clip_s = hi_s;
        end
        else if (sum_s < lo_s)
        begin
            clip_s = lo_s;
        end
        else
        begin
            clip_s = sum_s;
        end
    end

    // narrow to format width, offset formats get the msb flipped back
    always_comb
    begin
        result_sample = '0;
        if (fmt_ok)
        begin
            case (wcls)
                W8:
                begin
                    result_sample = {24'b0, clip_s[7] ^ off_flag, clip_s[6:0]};
                end
                W16:
                begin
                    result_sample = {16'b0, clip_s[15] ^ off_flag, clip_s[14:0]};
                end
                W32:
                begin
                    result_sample = clip_s[31:0];
                end
                default:
                begin
                    result_sample = '0;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/saturating_sample_add_sub_top.sv =====
// saturating sample add / subtract
// slave stream: s_axis_tdata carries two samples per transfer, s_axis_tlast
// marks the last sample of a buffer. master stream: one saturated result per
// input transfer, m_axis_tlast copies the input tlast.
// config channel: cfg_index 0 selects sample_format (u8, s8, offset u8, u16,
// s16, offset u16, s32), index 1 selects operation (add, first minus second).
// cfg_ready is always high; write config only while the stream is idle.
// an input transfer passes the input register, then the result register,
// before m_axis_tvalid rises. throughput: one transfer per cycle while the
// sink does not stall, set by the two-register pipeline with one adder and
// clip stage between them.
// when the sink stalls, the result register holds and the input register
// still takes one more transfer; s_axis_tready drops once both are full.
// reset: both pipeline stages empty, format u8, operation add.
module saturating_sample_add_sub_top
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [2*ssas_pkg::SAMPLE_W-1:0]      s_axis_tdata,  // first_sample, second_sample
    input  logic                                 s_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [ssas_pkg::SAMPLE_W-1:0]        m_axis_tdata,  // result_sample
    output logic                                 m_axis_tlast,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ssas_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ssas_pkg::CFG_DATA_W-1:0]      cfg_data
);

    ssas_pkg::ssas_cfg_t                 cfg;
    logic                                in_v_reg;
    logic [ssas_pkg::SAMPLE_W-1:0]       a_reg;
    logic [ssas_pkg::SAMPLE_W-1:0]       b_reg;
    logic                                in_last_reg;
    logic                                out_v_reg;
    logic [ssas_pkg::SAMPLE_W-1:0]       res_reg;
    logic [ssas_pkg::SAMPLE_W-1:0]       res_next;
    logic                                out_last_reg;
    logic                                adv_out;
    logic                                adv_in;

    ssas_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ssas_alu u_alu
    (
        .cfg           (cfg),
        .first_sample  (a_reg),
        .second_sample (b_reg),
        .result_sample (res_next)
    );

    assign adv_out       = !out_v_reg || m_axis_tready;
    assign adv_in        = !in_v_reg || adv_out;
    assign s_axis_tready = adv_in;
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = res_reg;
    assign m_axis_tlast  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (adv_in)
            begin
                in_v_reg <= s_axis_tvalid;
            end
            if (adv_out)
            begin
                out_v_reg <= in_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_in && s_axis_tvalid)
        begin
            a_reg       <= s_axis_tdata[ssas_pkg::SAMPLE_W-1:0];
            b_reg       <= s_axis_tdata[2*ssas_pkg::SAMPLE_W-1:ssas_pkg::SAMPLE_W];
            in_last_reg <= s_axis_tlast;
        end
        if (adv_out && in_v_reg)
        begin
            res_reg      <= res_next;
            out_last_reg <= in_last_reg;
        end
    end

endmodule

// ===== rtl/core/ssas_checker.sv =====
`include "assert_macros.svh"

module ssas_checker
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    input  logic                                 s_axis_tready,
    input  logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    input  logic [ssas_pkg::SAMPLE_W-1:0]        m_axis_tdata,
    input  logic                                 m_axis_tlast,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready
);

    // stalled result stays offered
    `SSAS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

    // stalled result payload unchanged
    `SSAS_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // empty result stage never blocks the input side
    `SSAS_ASSERT_NOW(a_in_free, !m_axis_tvalid, s_axis_tready)

    // no result appears unless an input transfer has first passed through the input register
    `SSAS_ASSERT_NEXT(a_no_spurious, !m_axis_tvalid && !$past(s_axis_tvalid && s_axis_tready), !m_axis_tvalid)

    // config writes are never refused
    `SSAS_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind saturating_sample_add_sub_top ssas_checker u_ssas_checker (.*);
